FILE: rtl/cau_pkg.sv
// Package: shared types, opcodes and constants for the complex arithmetic unit.
package cau_pkg;

   localparam int FracBits = 16;
   localparam int WordBits = 32;
   localparam int FieldBits = 32;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_SCALE = 3'd3,
      OP_DIV   = 3'd4,
      OP_CONJ  = 3'd5,
      OP_MAG   = 3'd6,
      OP_EQ    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      logic [FieldBits-1:0] res_re;
      logic [FieldBits-1:0] res_im;
      logic                 is_equal;
      logic [1:0]           status;
   } result_type;

endpackage

FILE: rtl/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cau_div #(
   parameter int NumBits = 64,
   parameter int DenBits = 32
) (
   input  logic               clock,
   input  logic               advance,
   input  logic [NumBits-1:0] num_in,
   input  logic [DenBits-1:0] den_in,
   output logic [NumBits-1:0] quo_out
);

   logic [NumBits-1:0] num_ff [NumBits+1];
   logic [NumBits-1:0] quo_ff [NumBits+1];
   logic [DenBits:0]   rem_ff [NumBits+1];
   logic [DenBits-1:0] den_ff [NumBits+1];

   always_comb begin
      num_ff[0] = num_in;
      quo_ff[0] = '0;
      rem_ff[0] = '0;
      den_ff[0] = den_in;
   end

   for (genvar g = 0; g < NumBits; g++) begin : g_stage
      logic [DenBits+1:0] trial_in;
      logic [DenBits+1:0] shifted_in;
      always_comb begin
         shifted_in = {rem_ff[g], num_ff[g][NumBits-1-g]};
         trial_in   = shifted_in - {2'b00, den_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[g+1] <= num_ff[g];
            den_ff[g+1] <= den_ff[g];
            if (!trial_in[DenBits+1]) begin
               rem_ff[g+1] <= trial_in[DenBits:0];
               quo_ff[g+1] <= {quo_ff[g][NumBits-2:0], 1'b1};
            end else begin
               rem_ff[g+1] <= shifted_in[DenBits:0];
               quo_ff[g+1] <= {quo_ff[g][NumBits-2:0], 1'b0};
            end
         end
      end
   end

   assign quo_out = quo_ff[NumBits];

endmodule

FILE: rtl/cau_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cau_sqrt #(
   parameter int RadBits = 64
) (
   input  logic               clock,
   input  logic               advance,
   input  logic [RadBits-1:0] rad_in,
   output logic [RadBits/2-1:0] root_out
);

   localparam int RootBits = RadBits / 2;

   logic [RadBits-1:0]  rad_ff  [RootBits+1];
   logic [RootBits-1:0] root_ff [RootBits+1];
   logic [RootBits+1:0] rem_ff  [RootBits+1];

   always_comb begin
      rad_ff[0]  = rad_in;
      root_ff[0] = '0;
      rem_ff[0]  = '0;
   end

   for (genvar g = 0; g < RootBits; g++) begin : g_stage
      logic [RootBits+3:0] cur_in;
      logic [RootBits+3:0] trial_in;
      always_comb begin
         cur_in   = {rem_ff[g], rad_ff[g][RadBits-1-2*g -: 2]};
         trial_in = cur_in - {2'b00, root_ff[g], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[g+1] <= rad_ff[g];
            if (!trial_in[RootBits+3]) begin
               rem_ff[g+1]  <= trial_in[RootBits+1:0];
               root_ff[g+1] <= {root_ff[g][RootBits-2:0], 1'b1};
            end else begin
               rem_ff[g+1]  <= cur_in[RootBits+1:0];
               root_ff[g+1] <= {root_ff[g][RootBits-2:0], 1'b0};
            end
         end
      end
   end

   assign root_out = root_ff[RootBits];

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: front end, long units, result stage.
// Operand fields are WORD_BITS wide, capped at 32.
// Throughput: one word per cycle; the pipe advances whenever the output stage can move.
// The divider and square root units are fully pipelined, one bit per stage.
// Reset: synchronous, active high; clears valid bits only, payload is not reset.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FracBits,
   parameter int WORD_BITS = cau_pkg::WordBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: req_type[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99],
   // scalar[162:131], zero fill to 168
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: res_re[31:0], res_im[63:32], is_equal[64], status[66:65], zero fill to 72
   output logic [71:0]  rsp_tdata
);

   localparam int EB    = (WORD_BITS > cau_pkg::FieldBits) ? cau_pkg::FieldBits : WORD_BITS;
   localparam int PB    = 2 * EB + 2;
   localparam int NB    = EB + FRAC_BITS;
   localparam int DLAT  = NB;
   localparam int SLAT  = EB;
   localparam int DEPTH = 3 + ((DLAT > SLAT) ? DLAT : SLAT);
   localparam logic signed [PB-1:0] SatHi = PB'((64'sd1 <<< (EB - 1)) - 64'sd1);
   localparam logic signed [PB-1:0] SatLo = -SatHi - PB'(1);

   logic advance;
   logic [DEPTH:0] vld_ff;
   logic [DEPTH:0] vld_in;

   // stage 0: register inputs
   logic [2:0]             op_ff;
   logic signed [EB-1:0]   ar_ff, ai_ff, br_ff, bi_ff, sc_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff <= req_tdata[2:0];
         ar_ff <= req_tdata[3 +: EB];
         ai_ff <= req_tdata[35 +: EB];
         br_ff <= req_tdata[67 +: EB];
         bi_ff <= req_tdata[99 +: EB];
         sc_ff <= req_tdata[131 +: EB];
      end
   end

   // stage 1: products
   logic signed [PB-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [PB-1:0] q0_ff, q1_ff;
   logic [2:0]           op1_ff;
   logic signed [EB-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff, sc1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff  <= PB'(ar_ff) * PB'(br_ff);
         p1_ff  <= PB'(ai_ff) * PB'(bi_ff);
         p2_ff  <= PB'(ar_ff) * PB'(bi_ff);
         p3_ff  <= PB'(ai_ff) * PB'(br_ff);
         q0_ff  <= PB'(ar_ff) * PB'(sc_ff);
         q1_ff  <= PB'(ai_ff) * PB'(sc_ff);
         op1_ff <= op_ff;
         ar1_ff <= ar_ff; ai1_ff <= ai_ff; br1_ff <= br_ff; bi1_ff <= bi_ff;
         sc1_ff <= sc_ff;
      end
   end

   // stage 2: sums, short results, unit operands
   logic signed [PB-1:0] sr_in, si_in;
   logic [PB-1:0]        ur_in, ui_in;
   logic signed [PB-1:0] are_in, aie_in, abr_in, abi_in;
   always_comb begin
      sr_in = '0; si_in = '0;
      unique case (cau_pkg::op_type'(op1_ff))
         cau_pkg::OP_ADD: begin
            sr_in = PB'(ar1_ff) + PB'(br1_ff); si_in = PB'(ai1_ff) + PB'(bi1_ff);
         end
         cau_pkg::OP_SUB: begin
            sr_in = PB'(ar1_ff) - PB'(br1_ff); si_in = PB'(ai1_ff) - PB'(bi1_ff);
         end
         cau_pkg::OP_MUL: begin
            sr_in = p0_ff - p1_ff; si_in = p2_ff + p3_ff;
         end
         cau_pkg::OP_SCALE: begin
            sr_in = q0_ff; si_in = q1_ff;
         end
         cau_pkg::OP_CONJ: begin
            sr_in = PB'(ar1_ff); si_in = -PB'(ai1_ff);
         end
         default: begin
            sr_in = '0; si_in = '0;
         end
      endcase
      are_in = PB'(ar1_ff); aie_in = PB'(ai1_ff);
      abr_in = are_in[PB-1] ? -are_in : are_in;
      abi_in = aie_in[PB-1] ? -aie_in : aie_in;
      ur_in  = abr_in;
      ui_in  = abi_in;
   end

   logic signed [PB-1:0] sr_ff, si_ff;
   logic [2:0]           op2_ff;
   logic                 eq2_ff, dz2_ff;
   logic                 nr2_ff, ni2_ff;
   logic [NB-1:0]        nr_num_ff, ni_num_ff;
   logic [EB-1:0]        den_ff;
   logic                 dneg_ff;
   logic [2*EB-1:0]      rad_sum_in;
   // signed squares are never negative, so no magnitude step is needed first
   logic signed [2*EB-1:0] sqr_in, sqi_in;
   always_comb begin
      sqr_in = ar1_ff * ar1_ff;
      sqi_in = ai1_ff * ai1_ff;
   end
   logic [2*EB-1:0]      sqr_ff, sqi_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_ff     <= sr_in;
         si_ff     <= si_in;
         op2_ff    <= op1_ff;
         eq2_ff    <= (op1_ff == cau_pkg::OP_EQ) && (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         dz2_ff    <= (sc1_ff == '0);
         nr2_ff    <= ar1_ff[EB-1];
         ni2_ff    <= ai1_ff[EB-1];
         nr_num_ff <= NB'(ur_in[EB:0]) << FRAC_BITS;
         ni_num_ff <= NB'(ui_in[EB:0]) << FRAC_BITS;
         dneg_ff   <= sc1_ff[EB-1];
         den_ff    <= sc1_ff[EB-1] ? EB'(-sc1_ff) : EB'(sc1_ff);
         sqr_ff    <= sqr_in;
         sqi_ff    <= sqi_in;
      end
   end
   always_comb rad_sum_in = sqr_ff + sqi_ff;

   // long units
   logic [NB-1:0]   qr_out, qi_out;
   logic [EB-1:0]   root_out;
   cau_div #(.NumBits(NB), .DenBits(EB)) u_div_re (
      .clock(clock), .advance(advance), .num_in(nr_num_ff), .den_in(den_ff),
      .quo_out(qr_out));
   cau_div #(.NumBits(NB), .DenBits(EB)) u_div_im (
      .clock(clock), .advance(advance), .num_in(ni_num_ff), .den_in(den_ff),
      .quo_out(qi_out));
   cau_sqrt #(.RadBits(2 * EB)) u_sqrt (
      .clock(clock), .advance(advance), .rad_in(rad_sum_in), .root_out(root_out));

   // delay lines, aligned to the slower unit
   localparam int DL = (DLAT > SLAT) ? DLAT : SLAT;
   typedef struct packed {
      logic [PB-1:0] sr;
      logic [PB-1:0] si;
      logic [2:0]    op;
      logic          eq;
      logic          dz;
      logic          nr;
      logic          ni;
      logic          dneg;
   } side_type;
   side_type side_ff [DL+1];
   always_comb side_ff[0] = '{sr: sr_ff, si: si_ff, op: op2_ff, eq: eq2_ff, dz: dz2_ff,
                              nr: nr2_ff, ni: ni2_ff, dneg: dneg_ff};
   for (genvar g = 0; g < DL; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (advance) side_ff[g+1] <= side_ff[g];
      end
   end

   logic [NB-1:0] qr_d_ff [DL-DLAT+1];
   logic [NB-1:0] qi_d_ff [DL-DLAT+1];
   logic [EB-1:0] rt_d_ff [DL-SLAT+1];
   always_comb begin
      qr_d_ff[0] = qr_out; qi_d_ff[0] = qi_out; rt_d_ff[0] = root_out;
   end
   for (genvar g = 0; g < DL - DLAT; g++) begin : g_qd
      always_ff @(posedge clock) begin
         if (advance) begin
            qr_d_ff[g+1] <= qr_d_ff[g];
            qi_d_ff[g+1] <= qi_d_ff[g];
         end
      end
   end
   for (genvar g = 0; g < DL - SLAT; g++) begin : g_rd
      always_ff @(posedge clock) begin
         if (advance) rt_d_ff[g+1] <= rt_d_ff[g];
      end
   end

   // final stage: truncate, sign fix, saturate
   side_type             sd;
   logic signed [NB+1:0] qre_in, qim_in;
   logic signed [PB-1:0] fr_in, fi_in, tr_in, ti_in;
   logic signed [NB+1:0] nb_hi, nb_lo;
   logic                 satr, sati;
   cau_pkg::result_type  res_in;
   logic signed [EB-1:0] outr, outi;
   always_comb begin
      sd     = side_ff[DL];
      qre_in = (sd.nr ^ sd.dneg) ? -$signed({2'b00, qr_d_ff[DL-DLAT]})
                                 : $signed({2'b00, qr_d_ff[DL-DLAT]});
      qim_in = (sd.ni ^ sd.dneg) ? -$signed({2'b00, qi_d_ff[DL-DLAT]})
                                 : $signed({2'b00, qi_d_ff[DL-DLAT]});
      tr_in  = $signed(sd.sr) >>> FRAC_BITS;
      ti_in  = $signed(sd.si) >>> FRAC_BITS;
      if ($signed(sd.sr) < 0 && (sd.sr & PB'((64'd1 << FRAC_BITS) - 1)) != '0)
         tr_in = tr_in + PB'(1);
      if ($signed(sd.si) < 0 && (sd.si & PB'((64'd1 << FRAC_BITS) - 1)) != '0)
         ti_in = ti_in + PB'(1);
      nb_hi = (NB+2)'(SatHi);
      nb_lo = (NB+2)'(SatLo);
      fr_in = '0; fi_in = '0; satr = 1'b0; sati = 1'b0;
      res_in = '0;
      unique case (cau_pkg::op_type'(sd.op)) inside
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
            fr_in = sd.sr; fi_in = sd.si;
         end
         cau_pkg::OP_MUL, cau_pkg::OP_SCALE: begin
            fr_in = tr_in; fi_in = ti_in;
         end
         cau_pkg::OP_MAG: begin
            fr_in = PB'({1'b0, rt_d_ff[DL-SLAT]});
         end
         default: begin
            fr_in = '0; fi_in = '0;
         end
      endcase
      if (fr_in > SatHi) begin outr = EB'(SatHi); satr = 1'b1; end
      else if (fr_in < SatLo) begin outr = EB'(SatLo); satr = 1'b1; end
      else outr = EB'(fr_in);
      if (fi_in > SatHi) begin outi = EB'(SatHi); sati = 1'b1; end
      else if (fi_in < SatLo) begin outi = EB'(SatLo); sati = 1'b1; end
      else outi = EB'(fi_in);
      if (sd.op == cau_pkg::OP_DIV) begin
         satr = 1'b0; sati = 1'b0;
         if (qre_in > nb_hi) begin outr = EB'(SatHi); satr = 1'b1; end
         else if (qre_in < nb_lo) begin outr = EB'(SatLo); satr = 1'b1; end
         else outr = EB'(qre_in);
         if (qim_in > nb_hi) begin outi = EB'(SatHi); sati = 1'b1; end
         else if (qim_in < nb_lo) begin outi = EB'(SatLo); sati = 1'b1; end
         else outi = EB'(qim_in);
         if (sd.dz) begin outr = '0; outi = '0; satr = 1'b0; sati = 1'b0; end
      end
      res_in.res_re   = cau_pkg::FieldBits'(outr);
      res_in.res_im   = cau_pkg::FieldBits'(outi);
      res_in.is_equal = sd.eq;
      if (sd.op == cau_pkg::OP_DIV && sd.dz) res_in.status = cau_pkg::ST_DIV0;
      else if (satr || sati) res_in.status = cau_pkg::ST_SAT;
      else res_in.status = cau_pkg::ST_OK;
   end

   cau_pkg::result_type res_ff;
   always_ff @(posedge clock) begin
      if (advance) res_ff <= res_in;
   end

   // valid chain: stages 0,1,2, DL unit stages, output
   assign advance    = !vld_ff[DEPTH] || rsp_tready;
   assign req_tready = advance;
   always_comb vld_in = {vld_ff[DEPTH-1:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   assign rsp_tvalid = vld_ff[DEPTH];
   assign rsp_tdata  = {5'b0, res_ff.status, res_ff.is_equal, res_ff.res_im, res_ff.res_re};

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[66:65] != 2'd3)
      else $error("bad status code");
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[63:0] == 64'd0)
      else $error("equality with nonzero result");
`endif

endmodule

FILE: tb/complex_arithmetic_unit_tb.sv
// Testbench for the complex arithmetic unit: random and directed words checked against a predictor.
module complex_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 4 + cau_pkg::WordBits + cau_pkg::FracBits;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      cau_pkg::op_type op;
      logic [31:0]     a_re, a_im, b_re, b_im, scalar;
   } cmd_type;

   typedef struct {
      logic [31:0] re, im;
      logic        eq;
      logic [1:0]  st;
   } answer_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;

   cmd_type    pending_cmds[$];
   answer_type expected_answers[$];
   int         error_count = 0;
   longint     cycle_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_cycles = 0;
   bit         req_taken = 0;

   complex_arithmetic_unit dut (.*);

   always #5 clock = ~clock;

   function automatic longint sat_word(longint x, ref bit flag);
      if (x > 64'sd2147483647) begin
         flag = 1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         flag = 1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // truncating shift of an exact 66-bit value toward zero
   function automatic longint trunc_frac(logic signed [65:0] v);
      logic signed [65:0] q;
      q = v >>> cau_pkg::FracBits;
      if (v < 0 && v[cau_pkg::FracBits-1:0] != 0) q = q + 1;
      if (q > 66'sd4294967295) return 64'sd4294967296;
      if (q < -66'sd4294967296) return -64'sd4294967296;
      return longint'(q);
   endfunction

   function automatic answer_type compute_answer(cmd_type c);
      answer_type r;
      longint ar, ai, br, bi, s, rr, ri;
      logic signed [65:0] p;
      logic [63:0] n, rt, bitv;
      bit flag;
      ar = longint'(signed'(c.a_re));
      ai = longint'(signed'(c.a_im));
      br = longint'(signed'(c.b_re));
      bi = longint'(signed'(c.b_im));
      s = longint'(signed'(c.scalar));
      rr = 0;
      ri = 0;
      flag = 0;
      r.eq = 0;
      r.st = cau_pkg::ST_OK;
      case (c.op)
         cau_pkg::OP_ADD: begin
            rr = sat_word(ar + br, flag);
            ri = sat_word(ai + bi, flag);
         end
         cau_pkg::OP_SUB: begin
            rr = sat_word(ar - br, flag);
            ri = sat_word(ai - bi, flag);
         end
         cau_pkg::OP_MUL: begin
            p = 66'(ar * br) - 66'(ai * bi);
            rr = sat_word(trunc_frac(p), flag);
            p = 66'(ar * bi) + 66'(ai * br);
            ri = sat_word(trunc_frac(p), flag);
         end
         cau_pkg::OP_SCALE: begin
            rr = sat_word(trunc_frac(66'(ar * s)), flag);
            ri = sat_word(trunc_frac(66'(ai * s)), flag);
         end
         cau_pkg::OP_DIV: begin
            if (s == 0) r.st = cau_pkg::ST_DIV0;
            else begin
               rr = sat_word((ar <<< cau_pkg::FracBits) / s, flag);
               ri = sat_word((ai <<< cau_pkg::FracBits) / s, flag);
            end
         end
         cau_pkg::OP_CONJ: begin
            rr = ar;
            ri = sat_word(-ai, flag);
         end
         cau_pkg::OP_MAG: begin
            n = 64'(ar * ar) + 64'(ai * ai);
            rt = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
               if (n >= rt + bitv) begin
                  n = n - (rt + bitv);
                  rt = (rt >> 1) + bitv;
               end else rt = rt >> 1;
               bitv = bitv >> 2;
            end
            rr = sat_word(longint'(rt), flag);
         end
         default: r.eq = (ar == br && ai == bi);
      endcase
      if (r.st == cau_pkg::ST_OK && flag) r.st = cau_pkg::ST_SAT;
      r.re = rr[31:0];
      r.im = ri[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cmd_type c;
               c = pending_cmds.pop_front();
               req_tdata <= {5'd0, c.scalar, c.b_im, c.b_re, c.a_im, c.a_re, c.op};
               req_tvalid <= 1;
            end else req_tvalid <= 0;
         end
      end
   end

   // receiver readiness
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= req_tvalid && req_tready;
      if (req_tvalid && req_tready) begin
         cmd_type c;
         c.op = cau_pkg::op_type'(req_tdata[2:0]);
         c.a_re = req_tdata[34:3];
         c.a_im = req_tdata[66:35];
         c.b_re = req_tdata[98:67];
         c.b_im = req_tdata[130:99];
         c.scalar = req_tdata[162:131];
         expected_answers.push_back(compute_answer(c));
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
         end else begin
            answer_type w;
            w = expected_answers.pop_front();
            if (rsp_tdata[31:0] !== w.re) report_mismatch("res_re", rsp_tdata[31:0], w.re);
            if (rsp_tdata[63:32] !== w.im) report_mismatch("res_im", rsp_tdata[63:32], w.im);
            if (rsp_tdata[64] !== w.eq) report_mismatch("is_equal", 32'(rsp_tdata[64]), 32'(w.eq));
            if (rsp_tdata[66:65] !== w.st) report_mismatch("status", 32'(rsp_tdata[66:65]), 32'(w.st));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(signed'($urandom_range(0, 8)) - 4);
         3: return 32'($urandom_range(0, 4)) << 16;
         4: return 32'(-(signed'($urandom_range(0, 4)) << 16));
         5, 6: return 32'(signed'($urandom_range(0, 32'h7ffff)) - 32'sh40000);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_cmd(cau_pkg::op_type op, logic [31:0] ar, ai, br, bi, s);
      cmd_type c;
      c.op = op;
      c.a_re = ar;
      c.a_im = ai;
      c.b_re = br;
      c.b_im = bi;
      c.scalar = s;
      pending_cmds.push_back(c);
   endtask

   task automatic queue_random(int count);
      cmd_type c;
      repeat (count) begin
         c.op = cau_pkg::op_type'(3'($urandom_range(7)));
         c.a_re = pick_value();
         c.a_im = pick_value();
         c.b_re = ($urandom_range(3) == 0) ? c.a_re : pick_value();
         c.b_im = ($urandom_range(3) == 0) ? c.a_im : pick_value();
         c.scalar = ($urandom_range(15) == 0) ? 32'd0 : pick_value();
         pending_cmds.push_back(c);
      end
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || expected_answers.size() > 0 || req_tvalid)
         @(posedge clock);
   endtask

   localparam logic [31:0] MAXV = 32'h7fffffff;
   localparam logic [31:0] MINV = 32'h80000000;
   localparam logic [31:0] ONE = 32'h00010000;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      // directed: field extremes and special cases
      queue_cmd(cau_pkg::OP_ADD, MAXV, MINV, MAXV, MINV, 0);
      queue_cmd(cau_pkg::OP_ADD, 32'h12345678, 32'hfedcba98, 32'h00010000, 32'hffff0000, 0);
      queue_cmd(cau_pkg::OP_SUB, MINV, MAXV, MAXV, MINV, 0);
      queue_cmd(cau_pkg::OP_SUB, 5, 7, 5, 7, 0);
      queue_cmd(cau_pkg::OP_MUL, ONE, ONE, ONE, ONE, 0);
      queue_cmd(cau_pkg::OP_MUL, MINV, MINV, MINV, MINV, 0);
      queue_cmd(cau_pkg::OP_MUL, MAXV, MINV, MINV, MAXV, 0);
      queue_cmd(cau_pkg::OP_MUL, 32'hffffffff, 1, 1, 32'hffffffff, 0);
      queue_cmd(cau_pkg::OP_SCALE, MAXV, MINV, 0, 0, MAXV);
      queue_cmd(cau_pkg::OP_SCALE, 32'hffffffff, 3, 0, 0, 32'h00008000);
      queue_cmd(cau_pkg::OP_SCALE, MINV, MINV, 0, 0, MINV);
      queue_cmd(cau_pkg::OP_DIV, ONE, MINV, 0, 0, 0);
      queue_cmd(cau_pkg::OP_DIV, MINV, MAXV, 0, 0, 32'hffffffff);
      queue_cmd(cau_pkg::OP_DIV, 32'hfffffffd, 7, 0, 0, 32'h00020000);
      queue_cmd(cau_pkg::OP_DIV, MAXV, MINV, 0, 0, MAXV);
      queue_cmd(cau_pkg::OP_CONJ, MINV, MINV, MAXV, MAXV, MAXV);
      queue_cmd(cau_pkg::OP_CONJ, MAXV, MAXV, 0, 0, 0);
      queue_cmd(cau_pkg::OP_MAG, MINV, MINV, 0, 0, 0);
      queue_cmd(cau_pkg::OP_MAG, 32'h00030000, 32'hfffc0000, 0, 0, 0);
      queue_cmd(cau_pkg::OP_MAG, 0, 0, 0, 0, 0);
      queue_cmd(cau_pkg::OP_MAG, MAXV, 1, 0, 0, 0);
      queue_cmd(cau_pkg::OP_EQ, MAXV, MINV, MAXV, MINV, 0);
      queue_cmd(cau_pkg::OP_EQ, MAXV, MINV, MAXV, MAXV, 0);
      queue_cmd(cau_pkg::OP_EQ, 0, 0, 32'hffffffff, 0, 32'hffffffff);
      drain();
      queue_random(400);
      drain();
      send_idle_pct = 78;
      queue_random(300);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 78;
      queue_random(300);
      drain();
      send_idle_pct = 26;
      recv_stall_pct = 26;
      queue_random(250);
      drain();
      // long receiver hold-off while words keep coming in
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 3 * LATENCY;
      queue_random(180);
      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/cau_sqrt.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
